// ===== design/lsdrs_pkg.sv =====
package lsdrs_pkg;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned RANK_W    = 16;
  localparam int unsigned COORD_W   = 64;
  localparam int unsigned PAYLOAD_W = RANK_W + 3 * COORD_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_COUNT_DRAIN,
    ST_PREFIX,
    ST_SCATTER,
    ST_SCATTER_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_PL,
    ST_EMIT_LD
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic cnt_issue;
    logic scat_issue;
    logic pfx_issue;
    logic clr_we;
    logic run_clr;
    logic fwd_clr;
    logic flip;
    logic emit_rd;
    logic emit_pl;
    logic emit_ld;
    logic emit_last;
    logic set_done;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

// ===== design/lsdrs_ctrl.sv =====
module lsdrs_ctrl #(
  parameter int unsigned NBINS  = 256,
  parameter int unsigned PASSES = 8,
  parameter int unsigned CW     = 7,
  parameter int unsigned CTRW   = 8,
  parameter int unsigned PW     = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_stall_o,
  input  logic [CW-1:0]     n_i,
  input  lsdrs_pkg::sts_t   sts_i,
  output lsdrs_pkg::cmd_t   cmd_o,
  output logic [CTRW-1:0]   ctr_o,
  output logic [PW-1:0]     pass_o
);

  localparam int unsigned CMPW = (CTRW > CW) ? CTRW : CW;

  lsdrs_pkg::ctrl_state_e state_q, state_d;
  logic [CTRW-1:0]        ctr_q, ctr_d;
  logic [PW-1:0]          pass_q, pass_d;
  logic                   last_item;

  assign last_item = (CMPW'(ctr_q) == (CMPW'(n_i) - CMPW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsdrs_pkg::ST_CLEAR;
      ctr_q   <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctr_d      = ctr_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      lsdrs_pkg::ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (ctr_q == CTRW'(NBINS - 1)) begin
          ctr_d   = '0;
          state_d = lsdrs_pkg::ST_IDLE;
        end else begin
          ctr_d = ctr_q + CTRW'(1);
        end
      end
      lsdrs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.fwd_clr = 1'b1;
          ctr_d         = '0;
          pass_d        = '0;
          state_d       = lsdrs_pkg::ST_COUNT;
        end
      end
      lsdrs_pkg::ST_COUNT: begin
        cmd_o.cnt_issue = 1'b1;
        if (last_item) begin
          ctr_d   = '0;
          state_d = lsdrs_pkg::ST_COUNT_DRAIN;
        end else begin
          ctr_d = ctr_q + CTRW'(1);
        end
      end
      lsdrs_pkg::ST_COUNT_DRAIN: begin
        if (ctr_q == CTRW'(1)) begin
          cmd_o.run_clr = 1'b1;
          ctr_d         = '0;
          state_d       = lsdrs_pkg::ST_PREFIX;
        end else begin
          ctr_d = ctr_q + CTRW'(1);
        end
      end
      lsdrs_pkg::ST_PREFIX: begin
        cmd_o.pfx_issue = 1'b1;
        if (ctr_q == CTRW'(NBINS - 1)) begin
          cmd_o.fwd_clr = 1'b1;
          ctr_d         = '0;
          state_d       = lsdrs_pkg::ST_SCATTER;
        end else begin
          ctr_d = ctr_q + CTRW'(1);
        end
      end
      lsdrs_pkg::ST_SCATTER: begin
        cmd_o.scat_issue = 1'b1;
        if (last_item) begin
          ctr_d   = '0;
          state_d = lsdrs_pkg::ST_SCATTER_DRAIN;
        end else begin
          ctr_d = ctr_q + CTRW'(1);
        end
      end
      lsdrs_pkg::ST_SCATTER_DRAIN: begin
        if (ctr_q == CTRW'(1)) begin
          cmd_o.flip = 1'b1;
          ctr_d      = '0;
          if (pass_q == PW'(PASSES - 1)) begin
            pass_d  = '0;
            state_d = lsdrs_pkg::ST_EMIT_RD;
          end else begin
            cmd_o.fwd_clr = 1'b1;
            pass_d        = pass_q + PW'(1);
            state_d       = lsdrs_pkg::ST_COUNT;
          end
        end else begin
          ctr_d = ctr_q + CTRW'(1);
        end
      end
      lsdrs_pkg::ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = lsdrs_pkg::ST_EMIT_PL;
      end
      lsdrs_pkg::ST_EMIT_PL: begin
        cmd_o.emit_pl = 1'b1;
        state_d       = lsdrs_pkg::ST_EMIT_LD;
      end
      lsdrs_pkg::ST_EMIT_LD: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_ld   = 1'b1;
          cmd_o.emit_last = last_item;
          if (last_item) begin
            cmd_o.set_done = 1'b1;
            ctr_d          = '0;
            state_d        = lsdrs_pkg::ST_IDLE;
          end else begin
            ctr_d   = ctr_q + CTRW'(1);
            state_d = lsdrs_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = lsdrs_pkg::ST_CLEAR;
        ctr_d   = '0;
      end
    endcase
  end

  assign ctr_o  = ctr_q;
  assign pass_o = pass_q;

endmodule

// ===== design/lsdrs_datapath.sv =====
module lsdrs_datapath #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned DIG_W       = 8,
  parameter int unsigned NBINS       = 256,
  parameter int unsigned IW          = 6,
  parameter int unsigned CW          = 7,
  parameter int unsigned CTRW        = 8,
  parameter int unsigned PW          = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lsdrs_pkg::cmd_t                   cmd_i,
  input  logic [CTRW-1:0]                   ctr_i,
  input  logic [PW-1:0]                     pass_i,
  output logic [CW-1:0]                     n_o,
  output lsdrs_pkg::sts_t                   sts_o,
  input  logic [lsdrs_pkg::KEY_W-1:0]       sort_key_i,
  input  logic [lsdrs_pkg::RANK_W-1:0]      owner_rank_i,
  input  logic [lsdrs_pkg::COORD_W-1:0]     coord_x_bits_i,
  input  logic [lsdrs_pkg::COORD_W-1:0]     coord_y_bits_i,
  input  logic [lsdrs_pkg::COORD_W-1:0]     coord_z_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lsdrs_pkg::KEY_W-1:0]       out_key_o,
  output logic [lsdrs_pkg::RANK_W-1:0]      out_rank_o,
  output logic [lsdrs_pkg::COORD_W-1:0]     out_x_bits_o,
  output logic [lsdrs_pkg::COORD_W-1:0]     out_y_bits_o,
  output logic [lsdrs_pkg::COORD_W-1:0]     out_z_bits_o,
  output logic                              out_last_o,
  output logic                              overflow_o
);

  localparam int unsigned KW = lsdrs_pkg::KEY_W;
  localparam int unsigned EW = KW + IW;
  localparam int unsigned RW = lsdrs_pkg::RANK_W;
  localparam int unsigned XW = lsdrs_pkg::COORD_W;
  localparam logic [KW-1:0] KMASK =
    (KEY_BITS >= KW) ? '1 : ((KW'(1) << KEY_BITS) - KW'(1));

  // record order with keys, ping-pong between passes
  logic [EW-1:0]                   ord0_mem [MAX_RECORDS];
  logic [EW-1:0]                   ord1_mem [MAX_RECORDS];
  logic [lsdrs_pkg::PAYLOAD_W-1:0] pl_mem   [MAX_RECORDS];
  logic [CW-1:0]                   cnt_mem  [NBINS];
  logic [CW-1:0]                   base_mem [NBINS];

  logic [EW-1:0]                   ord0_rd_q, ord1_rd_q, ord_rd;
  logic [lsdrs_pkg::PAYLOAD_W-1:0] pl_rd_q;
  logic [CW-1:0]                   cnt_rd_q, base_rd_q;

  logic [CW-1:0]    rec_cnt_q;
  logic             dropped_q;
  logic             sel_q;
  logic             v1_q, m1_q, v2_q, m2_q, p1_q;
  logic [EW-1:0]    e2_q;
  logic [DIG_W-1:0] d2_q, b1_q;
  logic [CW-1:0]    run_q;
  logic             fwd_v_q;
  logic [DIG_W-1:0] fwd_d_q;
  logic [CW-1:0]    fwd_val_q;
  logic             out_valid_q;

  logic             room, ld_we, sc_we, ord_re;
  logic [IW-1:0]    ord_raddr, ord_waddr;
  logic [EW-1:0]    ord_wdata;
  logic [5:0]       shift_amt;
  logic [KW-1:0]    key_sh;
  logic [DIG_W-1:0] digit, bin_raddr;
  logic             bin_re;
  logic [CW-1:0]    bin_val, bin_inc;
  logic             cnt_we, base_we;
  logic [DIG_W-1:0] cnt_waddr, base_waddr;
  logic [CW-1:0]    cnt_wdata, base_wdata;

  assign room      = (rec_cnt_q < CW'(MAX_RECORDS));
  assign ld_we     = cmd_i.load && room;
  assign sc_we     = v2_q && m2_q;
  assign ord_re    = cmd_i.cnt_issue || cmd_i.scat_issue || cmd_i.emit_rd;
  assign ord_raddr = ctr_i[IW-1:0];
  assign ord_waddr = ld_we ? rec_cnt_q[IW-1:0] : bin_val[IW-1:0];
  assign ord_wdata = ld_we ? {sort_key_i, rec_cnt_q[IW-1:0]} : e2_q;
  assign ord_rd    = sel_q ? ord1_rd_q : ord0_rd_q;

  always_ff @(posedge clk_i) begin
    if ((ld_we && !sel_q) || (sc_we && sel_q)) begin
      ord0_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord0_rd_q <= ord0_mem[ord_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ld_we && sel_q) || (sc_we && !sel_q)) begin
      ord1_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord1_rd_q <= ord1_mem[ord_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      pl_mem[rec_cnt_q[IW-1:0]] <= {owner_rank_i, coord_x_bits_i, coord_y_bits_i,
                                    coord_z_bits_i};
    end
    if (cmd_i.emit_pl) begin
      pl_rd_q <= pl_mem[ord_rd[IW-1:0]];
    end
  end

  // digit of the key at the current pass
  assign shift_amt = 6'(pass_i) * 6'(DIG_W);
  assign key_sh    = (ord_rd[EW-1:IW] & KMASK) >> shift_amt;
  assign digit     = key_sh[DIG_W-1:0];
  assign bin_raddr = v1_q ? digit : ctr_i[DIG_W-1:0];
  assign bin_re    = v1_q || cmd_i.pfx_issue;

  // forward the previous bin write, the read was issued at the same edge
  always_comb begin
    if (fwd_v_q && (fwd_d_q == d2_q)) begin
      bin_val = fwd_val_q;
    end else if (m2_q) begin
      bin_val = base_rd_q;
    end else begin
      bin_val = cnt_rd_q;
    end
    bin_inc = bin_val + CW'(1);
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = ctr_i[DIG_W-1:0];
    cnt_wdata = '0;
    if (v2_q && !m2_q) begin
      cnt_we    = 1'b1;
      cnt_waddr = d2_q;
      cnt_wdata = bin_inc;
    end else if (p1_q) begin
      cnt_we    = 1'b1;
      cnt_waddr = b1_q;
    end else if (cmd_i.clr_we) begin
      cnt_we = 1'b1;
    end
  end

  always_comb begin
    base_we    = 1'b0;
    base_waddr = b1_q;
    base_wdata = run_q;
    if (sc_we) begin
      base_we    = 1'b1;
      base_waddr = d2_q;
      base_wdata = bin_inc;
    end else if (p1_q) begin
      base_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (bin_re) begin
      cnt_rd_q <= cnt_mem[bin_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[base_waddr] <= base_wdata;
    end
    if (bin_re) begin
      base_rd_q <= base_mem[bin_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    e2_q      <= ord_rd;
    d2_q      <= digit;
    b1_q      <= ctr_i[DIG_W-1:0];
    fwd_d_q   <= d2_q;
    fwd_val_q <= bin_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_cnt_q <= '0;
      dropped_q <= 1'b0;
      sel_q     <= 1'b0;
      v1_q      <= 1'b0;
      m1_q      <= 1'b0;
      v2_q      <= 1'b0;
      m2_q      <= 1'b0;
      p1_q      <= 1'b0;
      run_q     <= '0;
      fwd_v_q   <= 1'b0;
    end else begin
      v1_q <= cmd_i.cnt_issue || cmd_i.scat_issue;
      m1_q <= cmd_i.scat_issue;
      v2_q <= v1_q;
      m2_q <= m1_q;
      p1_q <= cmd_i.pfx_issue;
      if (cmd_i.set_done) begin
        rec_cnt_q <= '0;
        dropped_q <= 1'b0;
      end else if (cmd_i.load) begin
        if (room) begin
          rec_cnt_q <= rec_cnt_q + CW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.flip) begin
        sel_q <= ~sel_q;
      end
      if (cmd_i.run_clr) begin
        run_q <= '0;
      end else if (p1_q) begin
        run_q <= run_q + cnt_rd_q;
      end
      if (cmd_i.fwd_clr) begin
        fwd_v_q <= 1'b0;
      end else if (v2_q) begin
        fwd_v_q <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_key_o    <= ord_rd[EW-1:IW];
      out_rank_o   <= pl_rd_q[3*XW +: RW];
      out_x_bits_o <= pl_rd_q[2*XW +: XW];
      out_y_bits_o <= pl_rd_q[XW +: XW];
      out_z_bits_o <= pl_rd_q[0 +: XW];
      out_last_o   <= cmd_i.emit_last;
      overflow_o   <= dropped_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign n_o            = rec_cnt_q;

endmodule

// ===== design/lsd_radix_sort_records.sv =====
// LSD radix sort of keyed records.
// Input channel: in_valid_i / in_stall_o carry one record per beat (key, owner
// rank, three coordinate words). last_in_set_i closes the set and starts the sort.
// Records are taken one per cycle while loading; a record beyond MAX_RECORDS is
// dropped, and every result beat of that set shows overflow_o.
// Once a set closes, in_stall_o stays high until its last result is loaded.
// Each sort runs passes = ceil(KEY_BITS / d) passes, with d the digit width; each pass
// counts the digits, forms the prefix sums and scatters the records, walking
// sequentially over the count and position memories (one read and one write port each).
// Output channel: out_valid_o / out_stall_i, one sorted record per beat in
// ascending key order, equal keys in arrival order, out_last_o on the final one.
// Each result beat is fetched by an order read, a payload read and an output load; a
// stall holds the output register and the next beat's output load waits for it.
// After reset the count memory is cleared bin by bin (2^d bins, 256 by default)
// while in_stall_o stays high.
module lsd_radix_sort_records #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned RADIX       = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lsdrs_pkg::KEY_W-1:0]   sort_key_i,
  input  logic [lsdrs_pkg::RANK_W-1:0]  owner_rank_i,
  input  logic [lsdrs_pkg::COORD_W-1:0] coord_x_bits_i,
  input  logic [lsdrs_pkg::COORD_W-1:0] coord_y_bits_i,
  input  logic [lsdrs_pkg::COORD_W-1:0] coord_z_bits_i,
  input  logic                          last_in_set_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lsdrs_pkg::KEY_W-1:0]   out_key_o,
  output logic [lsdrs_pkg::RANK_W-1:0]  out_rank_o,
  output logic [lsdrs_pkg::COORD_W-1:0] out_x_bits_o,
  output logic [lsdrs_pkg::COORD_W-1:0] out_y_bits_o,
  output logic [lsdrs_pkg::COORD_W-1:0] out_z_bits_o,
  output logic                          out_last_o,
  output logic                          overflow_o
);

  localparam int unsigned DIG_W  = $clog2(RADIX);
  localparam int unsigned NBINS  = 1 << DIG_W;
  localparam int unsigned PASSES = (KEY_BITS + DIG_W - 1) / DIG_W;
  localparam int unsigned IW     = $clog2(MAX_RECORDS);
  localparam int unsigned CW     = $clog2(MAX_RECORDS + 1);
  localparam int unsigned CTRW   = $clog2((NBINS > MAX_RECORDS) ? NBINS : MAX_RECORDS);
  localparam int unsigned PW     = $clog2(PASSES + 1);

  lsdrs_pkg::cmd_t  cmd;
  lsdrs_pkg::sts_t  sts;
  logic [CTRW-1:0]  ctr;
  logic [PW-1:0]    pass;
  logic [CW-1:0]    n;

  lsdrs_ctrl #(
    .NBINS  (NBINS),
    .PASSES (PASSES),
    .CW     (CW),
    .CTRW   (CTRW),
    .PW     (PW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (last_in_set_i),
    .in_stall_o (in_stall_o),
    .n_i        (n),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .ctr_o      (ctr),
    .pass_o     (pass)
  );

  lsdrs_datapath #(
    .MAX_RECORDS (MAX_RECORDS),
    .KEY_BITS    (KEY_BITS),
    .DIG_W       (DIG_W),
    .NBINS       (NBINS),
    .IW          (IW),
    .CW          (CW),
    .CTRW        (CTRW),
    .PW          (PW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .ctr_i          (ctr),
    .pass_i         (pass),
    .n_o            (n),
    .sts_o          (sts),
    .sort_key_i     (sort_key_i),
    .owner_rank_i   (owner_rank_i),
    .coord_x_bits_i (coord_x_bits_i),
    .coord_y_bits_i (coord_y_bits_i),
    .coord_z_bits_i (coord_z_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_key_o      (out_key_o),
    .out_rank_o     (out_rank_o),
    .out_x_bits_o   (out_x_bits_o),
    .out_y_bits_o   (out_y_bits_o),
    .out_z_bits_o   (out_z_bits_o),
    .out_last_o     (out_last_o),
    .overflow_o     (overflow_o)
  );

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    n <= CW'(MAX_RECORDS))
    else $error("record count above capacity");

  a_last_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_in_set_i) |=> in_stall_o)
    else $error("input taken after the set closed");

  a_emit_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_ld |-> (n != '0))
    else $error("result beat from an empty set");

  a_set_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_ld && cmd.emit_last) |=> (n == '0))
    else $error("record count not cleared after final beat");
`endif

endmodule
